>>> rtl/core/direct_mapped_writeback_cache_top_defines.svh
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_TOP_DEFINES_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_TOP_DEFINES_SVH

// same-cycle implication, reset masked
`define DMWC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cache check failed");

// next-cycle implication, reset masked
`define DMWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cache check failed");

`endif

>>> rtl/core/dmwc_pkg.sv
`timescale 1ns / 1ps
package dmwc_pkg;

	localparam int LINES           = 256;
	localparam int WORDS_PER_BLOCK = 4;
	localparam int MEMORY_WORDS    = 16384;

	localparam int DATA_W    = 32;
	localparam int LAT_W     = 10;
	localparam int KIND_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int ADDR_W    = $clog2(MEMORY_WORDS);
	localparam int OFF_W     = $clog2(WORDS_PER_BLOCK);
	localparam int LINE_W    = $clog2(LINES);
	localparam int TAG_W     = ADDR_W - OFF_W - LINE_W;
	localparam int SLOT_W    = LINE_W + OFF_W;
	localparam int CNT_W     = OFF_W + 1;

	localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MEM_RD_LAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEM_WR_LAT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CACHE_RD_LAT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CACHE_WR_LAT = 2'd3;

	localparam logic [LAT_W-1:0] MEM_RD_LAT_RST   = 10'd100;
	localparam logic [LAT_W-1:0] MEM_WR_LAT_RST   = 10'd50;
	localparam logic [LAT_W-1:0] CACHE_RD_LAT_RST = 10'd1;
	localparam logic [LAT_W-1:0] CACHE_WR_LAT_RST = 10'd1;

	typedef struct packed {
		logic              rd;
		logic              wr;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
	} bk_req_t;

endpackage

>>> rtl/core/dmwc_backing_mem.sv
`timescale 1ns / 1ps
module dmwc_backing_mem
	import dmwc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  bk_req_t           req,
	output logic [DATA_W-1:0] rdata,
	output logic              ready
);

	logic [DATA_W-1:0] mem [MEMORY_WORDS];
	logic [ADDR_W-1:0] clr_cnt_q;
	logic              clr_done_q;

	assign ready = clr_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_done_q <= 1'b0;
		end else if (!clr_done_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == {ADDR_W{1'b1}}) begin
				clr_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!clr_done_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (req.wr) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

>>> rtl/core/dmwc_ctrl.sv
`timescale 1ns / 1ps
module dmwc_ctrl
	import dmwc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [KIND_W-1:0]    kind,
	input  logic [ADDR_W-1:0]    word_address,
	input  logic [DATA_W-1:0]    write_data,
	output logic                 done,
	output logic [DATA_W-1:0]    read_data,
	output logic                 hit,
	output logic                 wrote_back,
	output logic [DATA_W-1:0]    total_time,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LAT_W-1:0]     cfg_data,
	output bk_req_t              bk_req,
	input  logic [DATA_W-1:0]    bk_rdata,
	input  logic                 bk_ready
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOOK = 3'd1;
	localparam logic [2:0] ST_WB   = 3'd2;
	localparam logic [2:0] ST_FILL = 3'd3;
	localparam logic [2:0] ST_ACC  = 3'd4;
	localparam logic [2:0] ST_RESP = 3'd5;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [OFF_W-1:0]  idx_q;
	logic [LINES-1:0]  valid_q;
	logic [LINES-1:0]  dirty_q;
	logic [DATA_W-1:0] total_q;
	logic              wb_q;
	logic              done_q;
	logic [LAT_W-1:0]  mem_rd_lat_q;
	logic [LAT_W-1:0]  mem_wr_lat_q;
	logic [LAT_W-1:0]  cache_rd_lat_q;
	logic [LAT_W-1:0]  cache_wr_lat_q;

	logic [KIND_W-1:0] kind_q;
	logic [ADDR_W-1:0] addr_q;
	logic [DATA_W-1:0] wdata_q;
	logic [TAG_W-1:0]  tag_rd_q;
	logic [TAG_W-1:0]  vtag_q;
	logic [DATA_W-1:0] line_rd_q;
	logic [DATA_W-1:0] rdata_q;
	logic              hit_q;
	logic              wrote_back_q;
	logic [DATA_W-1:0] total_out_q;

	logic [TAG_W-1:0]  tag_mem  [LINES];
	logic [DATA_W-1:0] line_mem [LINES * WORDS_PER_BLOCK];

	logic              accept;
	logic              acc_rw;
	logic [LINE_W-1:0] in_line;
	logic [OFF_W-1:0]  in_off;
	logic [LINE_W-1:0] line_q;
	logic [TAG_W-1:0]  tag_q;
	logic [SLOT_W-1:0] slot_q;
	logic              is_rd;
	logic              hit_c;
	logic              victim_dirty;
	logic              cnt_end;
	logic [LAT_W-1:0]  addend;
	logic [DATA_W-1:0] sum;
	logic              fin;
	logic              lr_en;
	logic [SLOT_W-1:0] lr_addr;
	logic              lw_en;
	logic [SLOT_W-1:0] lw_addr;
	logic [DATA_W-1:0] lw_data;

	assign busy    = (state_q != ST_IDLE) || !bk_ready;
	assign accept  = start && !busy;
	assign acc_rw  = (kind == KIND_READ) || (kind == KIND_WRITE);
	assign in_off  = word_address[OFF_W-1:0];
	assign in_line = word_address[OFF_W +: LINE_W];
	assign line_q  = addr_q[OFF_W +: LINE_W];
	assign tag_q   = addr_q[ADDR_W-1 -: TAG_W];
	assign slot_q  = addr_q[SLOT_W-1:0];
	assign is_rd   = (kind_q == KIND_READ);
	assign hit_c   = valid_q[line_q] && (tag_rd_q == tag_q);
	assign victim_dirty = valid_q[line_q] && dirty_q[line_q];
	assign cnt_end = cnt_q[OFF_W];

	always_comb begin
		addend = '0;
		unique case (state_q)
			ST_LOOK: addend = hit_c ? (is_rd ? cache_rd_lat_q : cache_wr_lat_q) : mem_rd_lat_q;
			ST_WB:   addend = mem_wr_lat_q;
			ST_ACC:  addend = cache_wr_lat_q;
			ST_RESP: addend = cache_rd_lat_q;
			default: addend = '0;
		endcase
	end

	assign sum = total_q + {{(DATA_W - LAT_W){1'b0}}, addend};
	assign fin = ((state_q == ST_LOOK) && hit_c) || ((state_q == ST_ACC) && !is_rd)
		|| (state_q == ST_RESP);

	always_comb begin
		lr_en        = 1'b0;
		lr_addr      = slot_q;
		lw_en        = 1'b0;
		lw_addr      = slot_q;
		lw_data      = wdata_q;
		bk_req.rd    = 1'b0;
		bk_req.wr    = 1'b0;
		bk_req.addr  = {tag_q, line_q, cnt_q[OFF_W-1:0]};
		bk_req.wdata = line_rd_q;
		unique case (state_q)
			ST_IDLE: begin
				lr_en   = accept && acc_rw;
				lr_addr = {in_line, in_off};
			end
			ST_LOOK: begin
				lw_en = hit_c && !is_rd;
			end
			ST_WB: begin
				lr_en       = !cnt_end;
				lr_addr     = {line_q, cnt_q[OFF_W-1:0]};
				bk_req.wr   = (cnt_q != '0);
				bk_req.addr = {vtag_q, line_q, idx_q};
			end
			ST_FILL: begin
				bk_req.rd = !cnt_end;
				lw_en     = (cnt_q != '0);
				lw_addr   = {line_q, idx_q};
				lw_data   = bk_rdata;
			end
			ST_ACC: begin
				lr_en = is_rd;
				lw_en = !is_rd;
			end
			ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			valid_q        <= '0;
			dirty_q        <= '0;
			total_q        <= '0;
			wb_q           <= 1'b0;
			done_q         <= 1'b0;
			mem_rd_lat_q   <= MEM_RD_LAT_RST;
			mem_wr_lat_q   <= MEM_WR_LAT_RST;
			cache_rd_lat_q <= CACHE_RD_LAT_RST;
			cache_wr_lat_q <= CACHE_WR_LAT_RST;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MEM_RD_LAT:   mem_rd_lat_q   <= cfg_data;
					CFG_MEM_WR_LAT:   mem_wr_lat_q   <= cfg_data;
					CFG_CACHE_RD_LAT: cache_rd_lat_q <= cfg_data;
					CFG_CACHE_WR_LAT: cache_wr_lat_q <= cfg_data;
					default: begin
					end
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (acc_rw) begin
							state_q <= ST_LOOK;
						end else begin
							done_q <= 1'b1;
							if (kind == KIND_CLEAR) begin
								total_q <= '0;
							end
						end
					end
				end
				ST_LOOK: begin
					total_q <= sum;
					if (hit_c) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
						if (!is_rd) begin
							dirty_q[line_q] <= 1'b1;
						end
					end else begin
						wb_q            <= victim_dirty;
						valid_q[line_q] <= 1'b1;
						dirty_q[line_q] <= 1'b0;
						cnt_q           <= '0;
						state_q         <= victim_dirty ? ST_WB : ST_FILL;
					end
				end
				ST_WB: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_end) begin
						cnt_q   <= '0;
						total_q <= sum;
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_end) begin
						cnt_q   <= '0;
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (is_rd) begin
						state_q <= ST_RESP;
					end else begin
						total_q         <= sum;
						dirty_q[line_q] <= 1'b1;
						done_q          <= 1'b1;
						state_q         <= ST_IDLE;
					end
				end
				ST_RESP: begin
					total_q <= sum;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= cnt_q[OFF_W-1:0];
		if (accept) begin
			kind_q  <= kind;
			addr_q  <= word_address;
			wdata_q <= write_data;
			tag_rd_q <= tag_mem[in_line];
		end
		if ((state_q == ST_LOOK) && !hit_c) begin
			tag_mem[line_q] <= tag_q;
			vtag_q          <= tag_rd_q;
		end
		if (lw_en) begin
			line_mem[lw_addr] <= lw_data;
		end
		if (lr_en) begin
			line_rd_q <= line_mem[lr_addr];
		end
		if (accept && !acc_rw) begin
			rdata_q      <= '0;
			hit_q        <= 1'b0;
			wrote_back_q <= 1'b0;
			total_out_q  <= (kind == KIND_CLEAR) ? '0 : total_q;
		end else if (fin) begin
			rdata_q      <= is_rd ? line_rd_q : '0;
			hit_q        <= (state_q == ST_LOOK);
			wrote_back_q <= (state_q == ST_LOOK) ? 1'b0 : wb_q;
			total_out_q  <= sum;
		end
	end

	assign done       = done_q;
	assign read_data  = rdata_q;
	assign hit        = hit_q;
	assign wrote_back = wrote_back_q;
	assign total_time = total_out_q;

endmodule

>>> rtl/core/direct_mapped_writeback_cache_top.sv
`timescale 1ns / 1ps
// Direct-mapped write-back cache over a 16K-word backing memory, with a
// running access-time total built from four latency registers.
// Requests: raise start with kind, word_address and write_data; the request
// is taken on a clock edge where busy is low. Kind read, write or clear.
// Results: done pulses for one cycle with read_data, hit, wrote_back and
// total_time; the receiver cannot stall and must take it then.
// Sequence: a clear or unused kind answers the cycle after acceptance; a hit
// answers from the lookup state, the tag and line having been read together
// at acceptance. A miss fills the line from backing memory, one word a cycle,
// after first writing back a dirty victim the same way, then passes the line
// memory access state (ACC) and, for a read, the response state (RESP).
// Back-to-back: busy drops as done rises, so the next request can be taken on
// the edge that takes the result; a run of hits alternates accept and lookup.
// Reset: all lines invalid, total zero, latencies to defaults; backing
// memory is swept to zero, all 16384 words, busy high meanwhile.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
module direct_mapped_writeback_cache_top
	import dmwc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [KIND_W-1:0]    kind,
	input  logic [ADDR_W-1:0]    word_address,
	input  logic [DATA_W-1:0]    write_data,
	output logic                 done,
	output logic [DATA_W-1:0]    read_data,
	output logic                 hit,
	output logic                 wrote_back,
	output logic [DATA_W-1:0]    total_time,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LAT_W-1:0]     cfg_data
);

	bk_req_t           bk_req;
	logic [DATA_W-1:0] bk_rdata;
	logic              bk_ready;

	dmwc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.word_address (word_address),
		.write_data   (write_data),
		.done         (done),
		.read_data    (read_data),
		.hit          (hit),
		.wrote_back   (wrote_back),
		.total_time   (total_time),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.bk_req       (bk_req),
		.bk_rdata     (bk_rdata),
		.bk_ready     (bk_ready)
	);

	dmwc_backing_mem u_bmem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (bk_req),
		.rdata  (bk_rdata),
		.ready  (bk_ready)
	);

endmodule

>>> rtl/core/dmwc_checker.sv
`timescale 1ns / 1ps
`include "direct_mapped_writeback_cache_top_defines.svh"
module dmwc_checker
	import dmwc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [KIND_W-1:0] kind,
	input logic              done,
	input logic              hit,
	input logic              wrote_back,
	input logic [DATA_W-1:0] total_time
);

	logic req_rw;
	logic req_clr;

	assign req_rw  = start && !busy && ((kind == KIND_READ) || (kind == KIND_WRITE));
	assign req_clr = start && !busy && (kind == KIND_CLEAR);

	`DMWC_ASSERT_NEXT(a_rw_goes_busy, clk, arst_n, req_rw, busy && !done)
	`DMWC_ASSERT_NEXT(a_clr_zero, clk, arst_n, req_clr, done && (total_time == '0))
	`DMWC_ASSERT_NOW(a_wb_not_hit, clk, arst_n, done && wrote_back, !hit)
	`DMWC_ASSERT_NEXT(a_done_single, clk, arst_n, done && !start, !done)

endmodule

bind direct_mapped_writeback_cache_top dmwc_checker u_dmwc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.kind       (kind),
	.done       (done),
	.hit        (hit),
	.wrote_back (wrote_back),
	.total_time (total_time)
);
